// File: hw/rtl/ordered_int_list_append_delete_unit_defines.svh
// assertion macros for the ordered integer list unit checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef ORDERED_INT_LIST_APPEND_DELETE_UNIT_DEFINES_SVH
`define ORDERED_INT_LIST_APPEND_DELETE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OILAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oilad: same-cycle check failed");

// next-cycle implication, disabled during reset
`define OILAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oilad: next-cycle check failed");

`endif

// File: hw/rtl/oilad_pkg.sv
// shared types and codes for the ordered integer list unit
// no dependencies
package oilad_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // search token handed from cell to cell during a delete
    typedef struct packed {
        logic tok;   // token present at this cell boundary
        logic fnd;   // a matching entry was removed upstream
    } t_tok;

endpackage

// File: hw/rtl/ordered_int_list_append_delete_unit.sv
// top level of the ordered integer list unit: control plus a chain of
// oilad_cell slots; uses oilad_pkg
//
//  port group          dir  timing
//  start/operation/value in  taken at an edge with start high and busy low
//  o_strobe/status/...   out one cycle per result, no back-pressure
//
// an append does not go busy: the result strobe follows the accepting edge
// and busy stays low, so appends may come every cycle while no delete scans.
// a delete scans the list: a token ripples head to tail through
// the cell chain one cell per cycle; busy is high until the result shows.
// synchronous active-low reset empties the list (count and sum to zero).
// the receiver cannot stall; each result is shown for one cycle only.
module ordered_int_list_append_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                i_operation,
    input  logic signed [oilad_pkg::DATA_W-1:0] i_value,
    output logic                                busy,
    output logic                                o_strobe,
    output logic        [oilad_pkg::STATUS_W-1:0] o_status,
    output logic        [$clog2(CAPACITY+1)-1:0]  o_count,
    output logic signed [oilad_pkg::DATA_W-1:0] o_total
);

    localparam int CW = $clog2(CAPACITY+1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                               r_state;
    logic                                 r_inj;
    logic signed [oilad_pkg::DATA_W-1:0]  r_key;
    logic        [CW-1:0]                 r_count;
    logic signed [oilad_pkg::DATA_W-1:0]  r_sum;
    logic        [oilad_pkg::STATUS_W-1:0] r_status;
    logic                                 r_strobe;

    oilad_pkg::t_tok                      w_tok [CAPACITY+1];
    logic signed [oilad_pkg::DATA_W-1:0]  w_val [CAPACITY];
    logic                                 w_full;
    logic                                 w_app;

    assign w_full = (r_count == CW'(CAPACITY));
    // append transaction that will be written into the slot at the tail
    assign w_app  = start && !busy && (i_operation == oilad_pkg::OP_APPEND) && !w_full;

    // token enters at the head
    assign w_tok[0] = '{tok: r_inj, fnd: 1'b0};

    // cell chain, head at index 0
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [oilad_pkg::DATA_W-1:0] w_nxt;
        if (k == CAPACITY-1) begin : g_last
            assign w_nxt = w_val[k];
        end else begin : g_mid
            assign w_nxt = w_val[k+1];
        end
        oilad_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok[k]),
            .i_key     (r_key),
            .i_nxt_val (w_nxt),
            .i_count   (r_count),
            .i_app     (w_app),
            .i_app_val (i_value),
            .o_tok     (w_tok[k+1]),
            .o_val     (w_val[k])
        );
    end

    // control, count, sum and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inj    <= 1'b0;
            r_count  <= '0;
            r_sum    <= '0;
            r_status <= oilad_pkg::ST_DONE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_inj    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_operation == oilad_pkg::OP_APPEND) begin
                            r_strobe <= 1'b1;
                            if (w_full) begin
                                r_status <= oilad_pkg::ST_FULL;
                            end else begin
                                r_status <= oilad_pkg::ST_DONE;
                                r_count  <= r_count + CW'(1);
                                r_sum    <= r_sum + i_value;
                            end
                        end else begin
                            r_key   <= i_value;
                            r_inj   <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // token has left the last cell
                    if (w_tok[CAPACITY].tok) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                        if (w_tok[CAPACITY].fnd) begin
                            r_status <= oilad_pkg::ST_DONE;
                            r_count  <= r_count - CW'(1);
                            r_sum    <= r_sum - r_key;
                        end else begin
                            r_status <= oilad_pkg::ST_NOT_FOUND;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state == S_SCAN);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_total  = r_sum;

endmodule

// File: hw/rtl/oilad_cell.sv
// one list slot: holds an entry, takes appends, and on a passing
// delete token compares and shifts in its tail-side neighbor; uses oilad_pkg
module oilad_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oilad_pkg::t_tok                   i_tok,
    input  logic signed [oilad_pkg::DATA_W-1:0] i_key,
    input  logic signed [oilad_pkg::DATA_W-1:0] i_nxt_val,
    input  logic        [CW-1:0]              i_count,
    input  logic                              i_app,
    input  logic signed [oilad_pkg::DATA_W-1:0] i_app_val,
    output oilad_pkg::t_tok                   o_tok,
    output logic signed [oilad_pkg::DATA_W-1:0] o_val
);

    logic signed [oilad_pkg::DATA_W-1:0] r_val;
    oilad_pkg::t_tok                     r_tok;
    logic                                w_valid;
    logic                                w_match;
    logic                                w_shift;

    // slot occupancy follows from the count, no per-entry valid bit
    assign w_valid = CW'(IDX) < i_count;
    assign w_match = i_tok.tok && w_valid && (r_val == i_key);
    // once the match is found here or upstream, close the gap
    assign w_shift = i_tok.tok && (i_tok.fnd || w_match);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_app && (i_count == CW'(IDX))) begin
            r_val <= i_app_val;
        end else if (w_shift) begin
            r_val <= i_nxt_val;
        end
    end

    // token stage toward the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.tok <= i_tok.tok;
            r_tok.fnd <= i_tok.tok && (i_tok.fnd || w_match);
        end
    end

    assign o_tok = r_tok;
    assign o_val = r_val;

endmodule

// File: hw/rtl/oilad_chk.sv
// port-level checker for the ordered integer list unit and its bind
// uses oilad_pkg and ordered_int_list_append_delete_unit_defines.svh
`include "ordered_int_list_append_delete_unit_defines.svh"

module oilad_chk #(
    parameter int CAPACITY = 64
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                i_operation,
    input logic                                busy,
    input logic                                o_strobe,
    input logic [oilad_pkg::STATUS_W-1:0]      o_status,
    input logic [$clog2(CAPACITY+1)-1:0]       o_count
);

    localparam int CW = $clog2(CAPACITY+1);

    logic w_acc_app;
    logic w_acc_del;
    logic w_status_ok;
    logic w_rep_full;

    assign w_acc_app = start && !busy && (i_operation == oilad_pkg::OP_APPEND);
    assign w_acc_del = start && !busy && (i_operation == oilad_pkg::OP_DELETE);

    // status code is one of the defined values
    assign w_status_ok = (o_status == oilad_pkg::ST_DONE) ||
                         (o_status == oilad_pkg::ST_FULL) ||
                         (o_status == oilad_pkg::ST_NOT_FOUND);
    // result reports a full list
    assign w_rep_full  = o_strobe && (o_status == oilad_pkg::ST_FULL);

    // append answers in the next cycle without going busy
    `OILAD_ASSERT_NXT(a_app_result, w_acc_app, o_strobe && !busy)
    // delete starts a scan and gives no result right away
    `OILAD_ASSERT_NXT(a_del_scan, w_acc_del, busy && !o_strobe)
    // only defined status codes are reported
    `OILAD_ASSERT_IMP(a_status_code, o_strobe, w_status_ok)
    // full is reported only at capacity
    `OILAD_ASSERT_IMP(a_full_count, w_rep_full, o_count == CW'(CAPACITY))

endmodule

bind ordered_int_list_append_delete_unit oilad_chk #(
    .CAPACITY (CAPACITY)
) u_oilad_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_operation (i_operation),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_count     (o_count)
);
